// ===== rtl/tvts_pkg.sv =====
// Shared types, constants and helpers for the two-voice tone sequencer.
package tvts_pkg;

   // Default sizes of the two stores
   localparam int SEQ_DEPTH_DEF    = 1024;
   localparam int NOTE_ENTRIES_DEF = 256;

   // Field widths
   localparam int ADDR_W   = 10;
   localparam int SUM_W    = 11;   // base + position before wrap
   localparam int GAP_W    = 7;
   localparam int PERIOD_W = 16;

   // Timer clock over 8 Hz units: 1 MHz / 8
   localparam logic [16:0] TONE_DIVIDEND = 17'd125000;
   localparam int          DIV_STEPS     = 17;

   localparam logic [GAP_W-1:0] GAP_RESET = 7'd12;

   // Input function codes
   typedef enum logic [2:0] {
      FN_TICK    = 3'd0,
      FN_PLAY    = 3'd1,
      FN_START   = 3'd2,
      FN_STOP    = 3'd3,
      FN_PAUSE   = 3'd4,
      FN_UNPAUSE = 3'd5,
      FN_NOTE_WR = 3'd6,
      FN_SEQ_WR  = 3'd7
   } func_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADDR_Q,
      ST_ADDR_R,
      ST_SEQ,
      ST_NOTE,
      ST_DIV,
      ST_DONE
   } state_type;

   // What a store fetch is for
   typedef enum logic [2:0] {
      PUR_SFX_NOTE,
      PUR_MUS_NOTE,
      PUR_KEEP_CUR,
      PUR_KEEP_NXT,
      PUR_SEQ_WR
   } purpose_type;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] seq_addr;
      logic [7:0]        seq_len;
      logic [7:0]        loop_index;
      logic [7:0]        entry_index;
      logic [7:0]        note_hz8;
      logic [7:0]        note_ms;
   } req_type;

   typedef struct packed {
      logic                tone_on;
      logic [PERIOD_W-1:0] tone_period;
      logic                sfx_active;
      logic                music_active;
      logic                paused;
   } rsp_type;

   // Silent tail is due: note long enough and within gap of its end
   function automatic logic tail_due(input logic tail, input logic [15:0] el,
                                     input logic [7:0] len, input logic [GAP_W-1:0] gap);
      logic [7:0] lim;
      lim = len - {1'b0, gap};
      return !tail && (len > {gap, 1'b0}) && (el >= {8'd0, lim});
   endfunction

endpackage

// ===== rtl/tvts_ram.sv =====
// Generic single-port-write RAM with registered read.
module tvts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tvts_amod.sv =====
// Sequence address wrap: (base + pos) mod depth by reciprocal multiply.
module tvts_amod #(
   parameter int SEQ_DEPTH = tvts_pkg::SEQ_DEPTH_DEF,
   localparam int AW = $clog2(SEQ_DEPTH)
) (
   input  logic                       clock,
   input  logic [tvts_pkg::SUM_W-1:0] sum,
   output logic [AW-1:0]              addr
);

   localparam int          SHIFT = 28;
   localparam logic [22:0] RECIP = 23'(((64'd1 << SHIFT) + SEQ_DEPTH - 1) / SEQ_DEPTH);

   logic [33:0] prod;
   logic [5:0]  quot_in, quot_ff;
   logic [27:0] qd, rem, fixed;

   // Stage one: quotient estimate
   assign prod    = 34'(sum) * 34'(RECIP);
   assign quot_in = prod[33:28];

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   // Stage two: remainder with one correction
   assign qd    = 28'(quot_ff) * 28'(SEQ_DEPTH);
   assign rem   = 28'(sum) - qd;
   assign fixed = (rem >= 28'(SEQ_DEPTH)) ? rem - 28'(SEQ_DEPTH) : rem;
   assign addr  = fixed[AW-1:0];

endmodule

// ===== rtl/tvts_div.sv =====
// Restoring divider, one quotient bit a cycle: 125000 / divisor.
module tvts_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [7:0]  divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic        busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [7:0]  rem_ff, dvs_ff;
   logic [16:0] quo_ff;
   logic [8:0]  trial, diff;
   logic        fits;

   // One trial subtraction
   assign trial = {rem_ff, quo_ff[16]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= tvts_pkg::TONE_DIVIDEND;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[7:0] : trial[7:0];
            quo_ff <= {quo_ff[15:0], fits};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(tvts_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[15:0];

endmodule

// ===== rtl/two_voice_tone_sequencer_top.sv =====
// Two-voice tone sequencer: control sequencer, stores, address wrap and divider.
//
// Input channel req_*: one word per tick (1 ms) or command. Result channel rsp_*:
// one word per input word with the tone state and mode flags after that word.
// csr_wr_en/csr_wr_data write the silent-tail length in ms; write it while idle.
// From acceptance, a command without a store access passes the exec and done
// states; a sequence store write adds the two address-wrap states; a note read
// that ends the work (a rest, or a silent current music note) adds the wrap and
// both store reads; a tick that checks the music's current and next note runs
// them twice; a pitched note adds the two chained store reads (sequence store,
// then note table) and the 17-step period divider. One word is in work at a
// time; req_stall is high from acceptance until its result is registered.
// The result register decouples the sides: a new word is accepted while a
// result waits, and work holds in its last state until rsp_stall drops.
// Reset clears flags, voice timers and the tone (off) and sets the tail length
// to 12 ms. The sequence store and note table are not cleared and must be
// written before they are played.
module two_voice_tone_sequencer_top #(
   parameter int SEQ_DEPTH    = tvts_pkg::SEQ_DEPTH_DEF,
   parameter int NOTE_ENTRIES = tvts_pkg::NOTE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tvts_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tvts_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [tvts_pkg::GAP_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(SEQ_DEPTH);
   localparam int NW = $clog2(NOTE_ENTRIES);

   // Control and voice state
   tvts_pkg::state_type   state_ff, state_in;
   tvts_pkg::purpose_type pur_ff, pur_in;
   tvts_pkg::req_type     req_ff, req_in;
   tvts_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic sfx_ff, sfx_in, bgm_ff, bgm_in, pause_ff, pause_in, tail_ff, tail_in;
   logic [tvts_pkg::ADDR_W-1:0] sfx_base_ff, sfx_base_in, mus_base_ff, mus_base_in;
   logic [7:0]  sfx_count_ff, sfx_count_in, sfx_pos_ff, sfx_pos_in;
   logic [7:0]  sfx_note_ms_ff, sfx_note_ms_in;
   logic [15:0] sfx_elapsed_ff, sfx_elapsed_in, mus_elapsed_ff, mus_elapsed_in;
   logic [7:0]  mus_count_ff, mus_count_in, mus_loop_ff, mus_loop_in;
   logic [7:0]  mus_pos_ff, mus_pos_in, mus_note_ms_ff, mus_note_ms_in;
   logic        tone_on_ff, tone_on_in;
   logic [15:0] tone_period_ff, tone_period_in;
   logic [tvts_pkg::GAP_W-1:0] gap_ff, gap_in;

   logic [7:0]  pend_pos_ff, pend_pos_in, cur_hz_ff, cur_hz_in;
   logic [tvts_pkg::SUM_W-1:0] addr_x_ff, addr_x_in;
   logic        id_oob_ff, id_oob_in;

   // Store and divider hookup
   logic [AW-1:0] seq_addr;
   logic          seq_wr_en;
   logic [7:0]    seq_rd;
   logic          note_wr_en;
   logic [15:0]   note_rd;
   logic          div_start, div_done;
   logic [7:0]    div_divisor;
   logic [15:0]   div_quo;

   tvts_amod #(.SEQ_DEPTH(SEQ_DEPTH)) u_amod (
      .clock (clock),
      .sum   (addr_x_ff),
      .addr  (seq_addr)
   );

   tvts_ram #(.WIDTH(8), .DEPTH(SEQ_DEPTH)) u_seq_ram (
      .clock   (clock),
      .wr_en   (seq_wr_en),
      .wr_addr (seq_addr),
      .wr_data (req_ff.entry_index),
      .rd_addr (seq_addr),
      .rd_data (seq_rd)
   );

   tvts_ram #(.WIDTH(16), .DEPTH(NOTE_ENTRIES)) u_note_ram (
      .clock   (clock),
      .wr_en   (note_wr_en),
      .wr_addr (req_ff.entry_index[NW-1:0]),
      .wr_data ({req_ff.note_hz8, req_ff.note_ms}),
      .rd_addr (seq_rd[NW-1:0]),
      .rd_data (note_rd)
   );

   tvts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state and datapath control
   always_comb begin
      logic [15:0] sfx_el, mus_el;
      logic [7:0]  nxt, mp, ehz, ems;
      logic [15:0] entry;

      state_in       = state_ff;
      pur_in         = pur_ff;
      req_in         = req_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      sfx_in         = sfx_ff;
      bgm_in         = bgm_ff;
      pause_in       = pause_ff;
      tail_in        = tail_ff;
      sfx_base_in    = sfx_base_ff;
      sfx_count_in   = sfx_count_ff;
      sfx_pos_in     = sfx_pos_ff;
      sfx_note_ms_in = sfx_note_ms_ff;
      sfx_elapsed_in = sfx_elapsed_ff;
      mus_base_in    = mus_base_ff;
      mus_count_in   = mus_count_ff;
      mus_loop_in    = mus_loop_ff;
      mus_pos_in     = mus_pos_ff;
      mus_note_ms_in = mus_note_ms_ff;
      mus_elapsed_in = mus_elapsed_ff;
      tone_on_in     = tone_on_ff;
      tone_period_in = tone_period_ff;
      gap_in         = csr_wr_en ? csr_wr_data : gap_ff;
      pend_pos_in    = pend_pos_ff;
      cur_hz_in      = cur_hz_ff;
      addr_x_in      = addr_x_ff;
      id_oob_in      = id_oob_ff;
      seq_wr_en      = 1'b0;
      note_wr_en     = 1'b0;
      div_start      = 1'b0;
      entry          = id_oob_ff ? 16'd0 : note_rd;
      ehz            = entry[15:8];
      ems            = entry[7:0];
      div_divisor    = ehz;
      sfx_el         = (sfx_elapsed_ff == 16'hFFFF) ? sfx_elapsed_ff : sfx_elapsed_ff + 16'd1;
      mus_el         = (mus_elapsed_ff == 16'hFFFF) ? mus_elapsed_ff : mus_elapsed_ff + 16'd1;
      nxt            = '0;
      mp             = '0;

      unique case (state_ff)
         tvts_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = tvts_pkg::ST_EXEC;
            end
         end

         tvts_pkg::ST_EXEC: begin
            state_in = tvts_pkg::ST_DONE;
            unique case (req_ff.func)
               tvts_pkg::FN_TICK: begin
                  sfx_elapsed_in = sfx_el;
                  mus_elapsed_in = mus_el;
                  if (sfx_ff) begin
                     if (sfx_el < {8'd0, sfx_note_ms_ff}) begin
                        if (tvts_pkg::tail_due(tail_ff, sfx_el, sfx_note_ms_ff, gap_ff)) begin
                           tone_on_in     = 1'b0;
                           tone_period_in = '0;
                           tail_in        = 1'b1;
                        end
                     end else begin
                        nxt = sfx_pos_ff + 8'd1;
                        if (nxt >= sfx_count_ff) begin
                           // effect over: hand back to the music
                           sfx_in       = 1'b0;
                           tail_in      = 1'b0;
                           sfx_count_in = '0;
                           sfx_pos_in   = nxt;
                           if (bgm_ff && !pause_ff) begin
                              mp          = (mus_pos_ff >= mus_count_ff) ? mus_loop_ff
                                                                         : mus_pos_ff;
                              pend_pos_in = mp;
                              pur_in      = tvts_pkg::PUR_MUS_NOTE;
                              addr_x_in   = tvts_pkg::SUM_W'(mus_base_ff) + tvts_pkg::SUM_W'(mp);
                              state_in    = tvts_pkg::ST_ADDR_Q;
                           end else begin
                              tone_on_in     = 1'b0;
                              tone_period_in = '0;
                           end
                        end else begin
                           pend_pos_in = nxt;
                           pur_in      = tvts_pkg::PUR_SFX_NOTE;
                           addr_x_in   = tvts_pkg::SUM_W'(sfx_base_ff) + tvts_pkg::SUM_W'(nxt);
                           state_in    = tvts_pkg::ST_ADDR_Q;
                        end
                     end
                  end else if (bgm_ff && !pause_ff) begin
                     if (mus_el < {8'd0, mus_note_ms_ff}) begin
                        // tail due: look at current and next note first
                        if (tvts_pkg::tail_due(tail_ff, mus_el, mus_note_ms_ff, gap_ff)) begin
                           pur_in    = tvts_pkg::PUR_KEEP_CUR;
                           addr_x_in = tvts_pkg::SUM_W'(mus_base_ff)
                                     + tvts_pkg::SUM_W'(mus_pos_ff);
                           state_in  = tvts_pkg::ST_ADDR_Q;
                        end
                     end else begin
                        nxt         = mus_pos_ff + 8'd1;
                        mp          = (nxt >= mus_count_ff) ? mus_loop_ff : nxt;
                        pend_pos_in = mp;
                        pur_in      = tvts_pkg::PUR_MUS_NOTE;
                        addr_x_in   = tvts_pkg::SUM_W'(mus_base_ff) + tvts_pkg::SUM_W'(mp);
                        state_in    = tvts_pkg::ST_ADDR_Q;
                     end
                  end
               end

               tvts_pkg::FN_PLAY: begin
                  sfx_base_in  = req_ff.seq_addr;
                  sfx_count_in = req_ff.seq_len;
                  sfx_in       = 1'b1;
                  tail_in      = 1'b0;
                  if (req_ff.seq_len == 8'd0) begin
                     tone_on_in     = 1'b0;
                     tone_period_in = '0;
                     sfx_note_ms_in = '0;
                     sfx_elapsed_in = '0;
                     sfx_pos_in     = '0;
                  end else begin
                     pend_pos_in = '0;
                     pur_in      = tvts_pkg::PUR_SFX_NOTE;
                     addr_x_in   = tvts_pkg::SUM_W'(req_ff.seq_addr);
                     state_in    = tvts_pkg::ST_ADDR_Q;
                  end
               end

               tvts_pkg::FN_START: begin
                  mus_base_in    = req_ff.seq_addr;
                  mus_count_in   = req_ff.seq_len;
                  mus_loop_in    = req_ff.loop_index;
                  pause_in       = 1'b0;
                  tail_in        = 1'b0;
                  bgm_in         = 1'b1;
                  mus_pos_in     = '0;
                  mus_note_ms_in = '0;
                  if (!sfx_ff) begin
                     mp          = (req_ff.seq_len == 8'd0) ? req_ff.loop_index : 8'd0;
                     pend_pos_in = mp;
                     pur_in      = tvts_pkg::PUR_MUS_NOTE;
                     addr_x_in   = tvts_pkg::SUM_W'(req_ff.seq_addr) + tvts_pkg::SUM_W'(mp);
                     state_in    = tvts_pkg::ST_ADDR_Q;
                  end
               end

               tvts_pkg::FN_STOP: begin
                  bgm_in     = 1'b0;
                  pause_in   = 1'b0;
                  tail_in    = 1'b0;
                  mus_pos_in = '0;
                  if (!sfx_ff) begin
                     tone_on_in     = 1'b0;
                     tone_period_in = '0;
                  end
               end

               tvts_pkg::FN_PAUSE: begin
                  pause_in = 1'b1;
                  if (!sfx_ff) begin
                     tone_on_in     = 1'b0;
                     tone_period_in = '0;
                  end
               end

               tvts_pkg::FN_UNPAUSE: begin
                  pause_in = 1'b0;
                  if (bgm_ff && !sfx_ff) begin
                     mp          = (mus_pos_ff >= mus_count_ff) ? mus_loop_ff : mus_pos_ff;
                     pend_pos_in = mp;
                     pur_in      = tvts_pkg::PUR_MUS_NOTE;
                     addr_x_in   = tvts_pkg::SUM_W'(mus_base_ff) + tvts_pkg::SUM_W'(mp);
                     state_in    = tvts_pkg::ST_ADDR_Q;
                  end
               end

               tvts_pkg::FN_NOTE_WR: begin
                  note_wr_en = {1'b0, req_ff.entry_index} < 9'(NOTE_ENTRIES);
               end

               tvts_pkg::FN_SEQ_WR: begin
                  pur_in    = tvts_pkg::PUR_SEQ_WR;
                  addr_x_in = tvts_pkg::SUM_W'(req_ff.seq_addr);
                  state_in  = tvts_pkg::ST_ADDR_Q;
               end
            endcase
         end

         tvts_pkg::ST_ADDR_Q: begin
            state_in = tvts_pkg::ST_ADDR_R;
         end

         // Wrapped address ready: write, or launch the sequence read
         tvts_pkg::ST_ADDR_R: begin
            if (pur_ff == tvts_pkg::PUR_SEQ_WR) begin
               seq_wr_en = 1'b1;
               state_in  = tvts_pkg::ST_DONE;
            end else begin
               state_in = tvts_pkg::ST_SEQ;
            end
         end

         // Note id read; note table read goes out now
         tvts_pkg::ST_SEQ: begin
            id_oob_in = {1'b0, seq_rd} >= 9'(NOTE_ENTRIES);
            state_in  = tvts_pkg::ST_NOTE;
         end

         tvts_pkg::ST_NOTE: begin
            state_in = tvts_pkg::ST_DONE;
            unique case (pur_ff)
               tvts_pkg::PUR_SFX_NOTE, tvts_pkg::PUR_MUS_NOTE: begin
                  if (pur_ff == tvts_pkg::PUR_SFX_NOTE) begin
                     sfx_pos_in     = pend_pos_ff;
                     sfx_note_ms_in = ems;
                     sfx_elapsed_in = '0;
                  end else begin
                     mus_pos_in     = pend_pos_ff;
                     mus_note_ms_in = ems;
                     mus_elapsed_in = '0;
                  end
                  tail_in = 1'b0;
                  if (ehz < 8'd2) begin
                     tone_on_in     = 1'b0;
                     tone_period_in = '0;
                  end else begin
                     div_start = 1'b1;
                     state_in  = tvts_pkg::ST_DIV;
                  end
               end
               tvts_pkg::PUR_KEEP_CUR: begin
                  if (ehz == 8'd0) begin
                     tone_on_in     = 1'b0;
                     tone_period_in = '0;
                     tail_in        = 1'b1;
                  end else begin
                     cur_hz_in = ehz;
                     nxt       = mus_pos_ff + 8'd1;
                     mp        = (nxt >= mus_count_ff) ? mus_loop_ff : nxt;
                     pur_in    = tvts_pkg::PUR_KEEP_NXT;
                     addr_x_in = tvts_pkg::SUM_W'(mus_base_ff) + tvts_pkg::SUM_W'(mp);
                     state_in  = tvts_pkg::ST_ADDR_Q;
                  end
               end
               tvts_pkg::PUR_KEEP_NXT: begin
                  if (!(ehz == 8'd0 || ehz == cur_hz_ff)) begin
                     tone_on_in     = 1'b0;
                     tone_period_in = '0;
                     tail_in        = 1'b1;
                  end
               end
               default: begin
                  state_in = tvts_pkg::ST_DONE;
               end
            endcase
         end

         tvts_pkg::ST_DIV: begin
            if (div_done) begin
               tone_on_in     = 1'b1;
               tone_period_in = div_quo - 16'd1;
               state_in       = tvts_pkg::ST_DONE;
            end
         end

         // Register the result word once the output slot is free
         tvts_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{tone_on: tone_on_ff, tone_period: tone_period_ff,
                                sfx_active: sfx_ff, music_active: bgm_ff,
                                paused: pause_ff};
               state_in     = tvts_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tvts_pkg::ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tvts_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         sfx_ff         <= 1'b0;
         bgm_ff         <= 1'b0;
         pause_ff       <= 1'b0;
         tail_ff        <= 1'b0;
         sfx_base_ff    <= '0;
         sfx_count_ff   <= '0;
         sfx_pos_ff     <= '0;
         sfx_note_ms_ff <= '0;
         sfx_elapsed_ff <= '0;
         mus_base_ff    <= '0;
         mus_count_ff   <= '0;
         mus_loop_ff    <= '0;
         mus_pos_ff     <= '0;
         mus_note_ms_ff <= '0;
         mus_elapsed_ff <= '0;
         tone_on_ff     <= 1'b0;
         tone_period_ff <= '0;
         gap_ff         <= tvts_pkg::GAP_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         sfx_ff         <= sfx_in;
         bgm_ff         <= bgm_in;
         pause_ff       <= pause_in;
         tail_ff        <= tail_in;
         sfx_base_ff    <= sfx_base_in;
         sfx_count_ff   <= sfx_count_in;
         sfx_pos_ff     <= sfx_pos_in;
         sfx_note_ms_ff <= sfx_note_ms_in;
         sfx_elapsed_ff <= sfx_elapsed_in;
         mus_base_ff    <= mus_base_in;
         mus_count_ff   <= mus_count_in;
         mus_loop_ff    <= mus_loop_in;
         mus_pos_ff     <= mus_pos_in;
         mus_note_ms_ff <= mus_note_ms_in;
         mus_elapsed_ff <= mus_elapsed_in;
         tone_on_ff     <= tone_on_in;
         tone_period_ff <= tone_period_in;
         gap_ff         <= gap_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      pur_ff      <= pur_in;
      pend_pos_ff <= pend_pos_in;
      cur_hz_ff   <= cur_hz_in;
      addr_x_ff   <= addr_x_in;
      id_oob_ff   <= id_oob_in;
   end

   assign req_stall = (state_ff != tvts_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A silenced tail always means the tone is off
   a_tail_silent: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> !tone_on_ff)
      else $error("tail flag set while tone runs");

   // Tone off carries a zero period
   a_off_period: assert property (@(posedge clock) disable iff (reset)
      !tone_on_ff |-> (tone_period_ff == 16'd0))
      else $error("nonzero period with tone off");

   // Divider finishes only while the sequencer waits on it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == tvts_pkg::ST_DIV))
      else $error("divider result outside divide state");

   // A new result word comes only from the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tvts_pkg::ST_DONE))
      else $error("result raised outside done state");

endmodule

// ===== tb/sv/tone_checker.sv =====
// Checker for the tone sequencer: predicts each result word and compares it.
module tone_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  tvts_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  tvts_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [tvts_pkg::GAP_W-1:0] csr_wr_data,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEQ_N  = 1024;
   localparam int NOTE_N = 256;

   // mode flag bits
   localparam int F_SFX   = 0;
   localparam int F_MUS   = 1;
   localparam int F_PAUSE = 2;
   localparam int F_TAIL  = 3;

   logic [7:0]  seq_mem [SEQ_N];
   logic [15:0] note_mem [NOTE_N];
   logic [6:0]  gap;
   logic [3:0]  flags;
   logic [9:0]  fx_base, mu_base;
   int unsigned fx_len, fx_pos, fx_el, fx_ms;
   int unsigned mu_len, mu_loop, mu_pos, mu_el, mu_ms;
   logic        tone_run;
   logic [15:0] tone_cmp;

   tvts_pkg::rsp_type expected_tone_q[$];

   assign pending = expected_tone_q.size();

   function automatic logic [15:0] note_at(logic [9:0] base, int unsigned pos);
      logic [9:0] a;
      a = 10'((int'(base) + pos) % SEQ_N);
      return note_mem[seq_mem[a]];
   endfunction

   function automatic void set_tone(int unsigned hz);
      if (hz < 2) begin
         tone_run = 0;
         tone_cmp = '0;
      end else begin
         tone_run = 1;
         tone_cmp = 16'(125000 / hz - 1);
      end
   endfunction

   function automatic void fx_note(int unsigned pos);
      logic [15:0] e;
      e = note_at(fx_base, pos);
      fx_pos = pos & 8'hFF;
      fx_ms = e[7:0];
      fx_el = 0;
      flags[F_TAIL] = 0;
      set_tone(e[15:8]);
   endfunction

   function automatic void mu_note(int unsigned pos);
      logic [15:0] e;
      if (pos >= mu_len) pos = mu_loop;
      e = note_at(mu_base, pos);
      mu_pos = pos & 8'hFF;
      mu_ms = e[7:0];
      mu_el = 0;
      flags[F_TAIL] = 0;
      set_tone(e[15:8]);
   endfunction

   // music holds the tone over the tail when next note rests or repeats pitch
   function automatic logic mu_holds_tone();
      int unsigned nxt;
      logic [15:0] e;
      logic [7:0] cur_hz, nxt_hz;
      nxt = (mu_pos + 1) & 8'hFF;
      if (nxt >= mu_len) nxt = mu_loop;
      e = note_at(mu_base, mu_pos);
      cur_hz = e[15:8];
      if (cur_hz == 0) return 0;
      e = note_at(mu_base, nxt);
      nxt_hz = e[15:8];
      return nxt_hz == 0 || nxt_hz == cur_hz;
   endfunction

   function automatic void tail_cut(int unsigned el, int unsigned len);
      if (flags[F_TAIL]) return;
      if (len <= 2 * gap) return;
      if (el < len - gap) return;
      if (!flags[F_SFX] && mu_holds_tone()) return;
      set_tone(0);
      flags[F_TAIL] = 1;
   endfunction

   function automatic void back_to_music();
      if (!flags[F_MUS] || flags[F_PAUSE]) set_tone(0);
      else mu_note(mu_pos);
   endfunction

   function automatic void ms_tick();
      int unsigned nxt;
      if (fx_el < 65535) fx_el++;
      if (mu_el < 65535) mu_el++;
      if (flags[F_SFX]) begin
         tail_cut(fx_el, fx_ms);
         if (fx_el < fx_ms) return;
         nxt = (fx_pos + 1) & 8'hFF;
         if (nxt >= fx_len) begin
            flags[F_SFX] = 0;
            flags[F_TAIL] = 0;
            fx_len = 0;
            fx_pos = nxt;
            back_to_music();
            return;
         end
         fx_note(nxt);
         return;
      end
      if (!flags[F_MUS] || flags[F_PAUSE]) return;
      tail_cut(mu_el, mu_ms);
      if (mu_el < mu_ms) return;
      nxt = (mu_pos + 1) & 8'hFF;
      if (nxt >= mu_len) nxt = mu_loop;
      mu_note(nxt);
   endfunction

   // apply one input word, return the tone and flags after it
   function automatic tvts_pkg::rsp_type play_word(tvts_pkg::req_type w);
      tvts_pkg::rsp_type r;
      case (w.func)
         tvts_pkg::FN_TICK: ms_tick();
         tvts_pkg::FN_PLAY: begin
            fx_base = w.seq_addr;
            fx_len = w.seq_len;
            flags[F_SFX] = 1;
            flags[F_TAIL] = 0;
            if (w.seq_len == 0) begin
               set_tone(0);
               fx_ms = 0;
               fx_el = 0;
               fx_pos = 0;
            end else fx_note(0);
         end
         tvts_pkg::FN_START: begin
            mu_base = w.seq_addr;
            mu_len = w.seq_len;
            mu_loop = w.loop_index;
            flags[F_PAUSE] = 0;
            flags[F_TAIL] = 0;
            flags[F_MUS] = 1;
            mu_pos = 0;
            mu_ms = 0;
            if (!flags[F_SFX]) back_to_music();
         end
         tvts_pkg::FN_STOP: begin
            flags[F_MUS] = 0;
            flags[F_PAUSE] = 0;
            flags[F_TAIL] = 0;
            mu_pos = 0;
            if (!flags[F_SFX]) set_tone(0);
         end
         tvts_pkg::FN_PAUSE: begin
            flags[F_PAUSE] = 1;
            if (!flags[F_SFX]) set_tone(0);
         end
         tvts_pkg::FN_UNPAUSE: begin
            flags[F_PAUSE] = 0;
            if (flags[F_MUS] && !flags[F_SFX]) back_to_music();
         end
         tvts_pkg::FN_NOTE_WR: note_mem[w.entry_index] = {w.note_hz8, w.note_ms};
         default: seq_mem[w.seq_addr] = w.entry_index;
      endcase
      r.tone_on = tone_run;
      r.tone_period = tone_cmp;
      r.sfx_active = flags[F_SFX];
      r.music_active = flags[F_MUS];
      r.paused = flags[F_PAUSE];
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      tvts_pkg::rsp_type want;
      if (reset) begin
         gap = tvts_pkg::GAP_RESET;
         flags = '0;
         fx_base = '0; fx_len = 0; fx_pos = 0; fx_el = 0; fx_ms = 0;
         mu_base = '0; mu_len = 0; mu_loop = 0; mu_pos = 0; mu_el = 0; mu_ms = 0;
         set_tone(0);
         expected_tone_q.delete();
      end else begin
         if (csr_wr_en) gap = csr_wr_data;
         if (req_valid && !req_stall) expected_tone_q.push_back(play_word(req_data));
         // compare result word with oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_tone_q.size() == 0) begin
               report("unexpected word", 1, 0);
            end else begin
               want = expected_tone_q.pop_front();
               if (rsp_data.tone_on !== want.tone_on)
                  report("tone_on", rsp_data.tone_on, want.tone_on);
               if (rsp_data.tone_period !== want.tone_period)
                  report("tone_period", rsp_data.tone_period, want.tone_period);
               if (rsp_data.sfx_active !== want.sfx_active)
                  report("sfx_active", rsp_data.sfx_active, want.sfx_active);
               if (rsp_data.music_active !== want.music_active)
                  report("music_active", rsp_data.music_active, want.music_active);
               if (rsp_data.paused !== want.paused)
                  report("paused", rsp_data.paused, want.paused);
            end
         end
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the tone sequencer: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       req_valid = 0;
   logic                       req_stall;
   tvts_pkg::req_type          req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 0;
   tvts_pkg::rsp_type          rsp_data;
   logic                       csr_wr_en = 0;
   logic [tvts_pkg::GAP_W-1:0] csr_wr_data = '0;
   int                         fail_count;
   int                         pending;
   int                         idle_pct = 0;
   int                         stall_pct = 0;

   always #4 clock = ~clock;

   two_voice_tone_sequencer_top DUT (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_wr_data
   );

   tone_checker CHK (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_wr_data,
      .fail_count, .pending
   );

   // receiver stalls at random
   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // run limit
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   task automatic send_word(tvts_pkg::req_type w);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_data = w;
      forever begin
         #1;
         if (!req_stall) break;
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_valid = 0;
      wait (pending == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_gap(logic [tvts_pkg::GAP_W-1:0] g);
      go_idle();
      @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = g;
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   function automatic tvts_pkg::req_type cmd(tvts_pkg::func_type f, int addr = 0,
                                             int len = 0, int loop_pos = 0, int idx = 0,
                                             int hz = 0, int ms = 0);
      tvts_pkg::req_type w;
      w.func = f;
      w.seq_addr = 10'(addr);
      w.seq_len = 8'(len);
      w.loop_index = 8'(loop_pos);
      w.entry_index = 8'(idx);
      w.note_hz8 = 8'(hz);
      w.note_ms = 8'(ms);
      return w;
   endfunction

   // random word, mostly ticks; phrases mostly short and based in the filled window
   function automatic tvts_pkg::req_type rand_word();
      tvts_pkg::req_type w;
      int p;
      w = tvts_pkg::req_type'($bits(tvts_pkg::req_type)'({$urandom, $urandom}));
      p = $urandom_range(0, 99);
      if (p < 74) w.func = tvts_pkg::FN_TICK;
      else if (p < 80) w.func = tvts_pkg::FN_PLAY;
      else if (p < 85) w.func = tvts_pkg::FN_START;
      else if (p < 87) w.func = tvts_pkg::FN_STOP;
      else if (p < 90) w.func = tvts_pkg::FN_PAUSE;
      else if (p < 93) w.func = tvts_pkg::FN_UNPAUSE;
      else if (p < 96) w.func = tvts_pkg::FN_NOTE_WR;
      else w.func = tvts_pkg::FN_SEQ_WR;
      if (w.func == tvts_pkg::FN_PLAY || w.func == tvts_pkg::FN_START)
         w.seq_addr = 10'($urandom_range(0, 255));
      if ($urandom_range(0, 9) != 0) w.seq_len = 8'($urandom_range(0, 8));
      if ($urandom_range(0, 3) != 0) w.loop_index = 8'($urandom_range(0, 8));
      if ($urandom_range(0, 9) != 0) w.note_ms = 8'($urandom_range(0, 40));
      if ($urandom_range(0, 2) == 0) w.note_hz8 = 8'($urandom_range(0, 3) * 40);
      return w;
   endfunction

   initial begin
      int pcts [4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{7, 7}};
      logic [tvts_pkg::GAP_W-1:0] gaps [4] = '{tvts_pkg::GAP_RESET, 7'd0, 7'd127, 7'd5};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // fill the note table and every sequence entry a phrase can reach
      for (int i = 0; i < 256; i++)
         send_word(cmd(tvts_pkg::FN_NOTE_WR, 0, 0, 0, i, $urandom_range(0, 255),
                       ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 40)));
      for (int i = 0; i < 512; i++)
         send_word(cmd(tvts_pkg::FN_SEQ_WR, i, 0, 0,
                       (i % 7 == 0) ? 10 : $urandom_range(0, 255)));
      for (int i = 1020; i < 1024; i++)
         send_word(cmd(tvts_pkg::FN_SEQ_WR, i, 0, 0, $urandom_range(0, 255)));

      // directed: extremes, every function, special cases
      send_word(cmd(tvts_pkg::FN_NOTE_WR, 0, 0, 0, 255, 255, 255));
      send_word(cmd(tvts_pkg::FN_NOTE_WR, 0, 0, 0, 10, 1, 60));
      send_word(cmd(tvts_pkg::FN_NOTE_WR, 0, 0, 0, 11, 2, 30));
      send_word(cmd(tvts_pkg::FN_SEQ_WR, 1023, 0, 0, 255));
      send_word(cmd(tvts_pkg::FN_SEQ_WR, 0, 0, 0, 11));
      send_word(cmd(tvts_pkg::FN_PLAY, 1023, 2));
      repeat (3) send_word(cmd(tvts_pkg::FN_TICK));
      send_word(cmd(tvts_pkg::FN_PLAY, 0, 0));
      send_word(cmd(tvts_pkg::FN_TICK));
      send_word(cmd(tvts_pkg::FN_START, 1020, 0, 200));
      send_word(cmd(tvts_pkg::FN_START, 1020, 8, 3));
      send_word(cmd(tvts_pkg::FN_PLAY, 5, 255));
      send_word(cmd(tvts_pkg::FN_PAUSE));
      repeat (3) send_word(cmd(tvts_pkg::FN_TICK));
      send_word(cmd(tvts_pkg::FN_UNPAUSE));
      send_word(cmd(tvts_pkg::FN_STOP));
      send_word(cmd(tvts_pkg::FN_START, 1023, 255, 255));
      send_word(cmd(tvts_pkg::FN_PAUSE));
      send_word(cmd(tvts_pkg::FN_UNPAUSE));
      send_word(cmd(tvts_pkg::FN_STOP));

      // random phases with different tail lengths and idling
      for (int ph = 0; ph < 4; ph++) begin
         write_gap(gaps[ph]);
         idle_pct = pcts[ph][0];
         stall_pct = pcts[ph][1];
         for (int i = 0; i < 200; i++) send_word(rand_word());
      end

      @(negedge clock);
      req_valid = 0;
      wait (pending == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
